// ===== hdl/hdvt_pkg.sv =====
// shared types and constants of the hashed direct value table
package hdvt_pkg;

  // fixed field widths
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int CNT_W     = 11;
  localparam int BUCKET_W  = 10;
  localparam int KIND_W    = 2;
  localparam int DIV_CNT_W = 6;

  // hash constants
  localparam logic [KEY_W-1:0] HASH_XOR_K  = 64'd61;
  localparam int               HASH_SH_A   = 16;
  localparam int               HASH_SH_B   = 3;
  localparam int               HASH_SH_C   = 4;
  localparam logic [31:0]      HASH_MUL_K  = 32'h27d4eb2d;
  localparam int               HASH_SH_D   = 15;

  // bucket count after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 2'd0,
    KIND_GET = 2'd1,
    KIND_DEL = 2'd2
  } kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FOLD,
    ST_DIV,
    ST_MEM,
    ST_RESP
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic clr_we;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic fold;
    logic div_step;
    logic mem_op;
    logic rsp_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic div_last;
  } sts_t;

endpackage

// ===== hdl/hdvt_if.sv =====
// request, response and configuration channel interfaces

interface hdvt_req_if;
  import hdvt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface hdvt_rsp_if;
  import hdvt_pkg::*;
  logic                valid;
  logic                ready;
  logic [VAL_W-1:0]    read_value;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, read_value, bucket, input ready);
  modport sink   (input valid, read_value, bucket, output ready);
endinterface

interface hdvt_cfg_if;
  import hdvt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/hdvt_ctrl.sv =====
// sequencer for clearing, hashing, remainder and table access
module hdvt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output hdvt_pkg::cmd_t cmd_o,
  input  hdvt_pkg::sts_t sts_i
);
  import hdvt_pkg::*;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (req_valid_i) state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_last) state_d = ST_MEM;
      ST_MEM:    state_d = ST_RESP;
      ST_RESP:   if (!rsp_valid_q || rsp_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_we = 1'b1;
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_MUL_LO: cmd_o.mul_lo = 1'b1;
      ST_MUL_HI: cmd_o.mul_hi = 1'b1;
      ST_FOLD:   cmd_o.fold = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_MEM:    cmd_o.mem_op = 1'b1;
      ST_RESP:   cmd_o.rsp_load = !rsp_valid_q || rsp_ready_i;
      default:   cmd_o = '0;
    endcase
  end

  // output slot occupancy
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

`ifndef SYNTHESIS
  // a pending response is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rsp_load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("response overwritten before taken");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("second request accepted while busy");

  // valid only rises from a response load
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(cmd_o.rsp_load))
    else $error("response valid without load");
`endif

endmodule

// ===== hdl/hdvt_dp.sv =====
// hash, serial remainder, bucket store and response registers
module hdvt_dp #(
  parameter int MAX_BUCKETS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hdvt_pkg::cmd_t           cmd_i,
  output hdvt_pkg::sts_t           sts_o,
  input  logic [hdvt_pkg::KIND_W-1:0]   kind_i,
  input  logic [hdvt_pkg::KEY_W-1:0]    key_i,
  input  logic [hdvt_pkg::VAL_W-1:0]    value_i,
  input  logic                     cfg_we_i,
  input  logic [hdvt_pkg::CNT_W-1:0]    cfg_data_i,
  output logic [hdvt_pkg::VAL_W-1:0]    read_value_o,
  output logic [hdvt_pkg::BUCKET_W-1:0] bucket_o
);
  import hdvt_pkg::*;

  localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     eff_count;
  logic [31:0]          count_ext;
  logic [IDX_W-1:0]     clr_q;
  kind_e                kind_q;
  logic [VAL_W-1:0]     value_q;
  logic [KEY_W-1:0]     h_q;
  logic [KEY_W-1:0]     lo_q;
  logic [KEY_W-1:0]     mixed;
  logic [KEY_W-1:0]     lo_prod;
  logic [31:0]          hi_prod;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W:0]       rem_trial;
  logic [CNT_W-1:0]     rem_next;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [31:0]          rem_ext;
  logic [IDX_W-1:0]     mem_idx;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_addr;
  logic [VAL_W-1:0]     mem_wdata;
  logic [VAL_W-1:0]     mem_q [MAX_BUCKETS];
  logic [VAL_W-1:0]     rd_q;
  logic [VAL_W-1:0]     read_value_q;
  logic [BUCKET_W-1:0]  bucket_q;

  // bucket count clamped into 1..MAX_BUCKETS
  assign count_ext = 32'(count_q);
  always_comb begin
    if (count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (count_ext > MAX_BUCKETS) begin
      eff_count = CNT_W'(MAX_BUCKETS);
    end else begin
      eff_count = count_q;
    end
  end

  // configuration register and clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) count_q <= cfg_data_i;
      if (cmd_i.clr_we) clr_q <= sts_o.clr_last ? '0 : clr_q + 1'b1;
    end
  end

  // first shift-xor-add steps of the hash
  always_comb begin
    mixed = key_i ^ HASH_XOR_K ^ (key_i >> HASH_SH_A);
    mixed = mixed + (mixed << HASH_SH_B);
    mixed = mixed ^ (mixed >> HASH_SH_C);
  end

  // 64x32 multiply split into low and high partial products
  assign lo_prod = 64'(h_q[31:0]) * 64'(HASH_MUL_K);
  assign hi_prod = h_q[63:32] * HASH_MUL_K;

  // one remainder bit per step
  assign rem_trial = {rem_q, h_q[KEY_W-1]};
  always_comb begin
    if (rem_trial >= {1'b0, eff_count}) begin
      rem_next = CNT_W'(rem_trial - {1'b0, eff_count});
    end else begin
      rem_next = rem_trial[CNT_W-1:0];
    end
  end

  // hash and remainder registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q     <= mixed;
      kind_q  <= kind_e'(kind_i);
      value_q <= value_i;
    end
    if (cmd_i.mul_lo) lo_q <= lo_prod;
    if (cmd_i.mul_hi) h_q <= lo_q + {hi_prod, 32'b0};
    if (cmd_i.fold) begin
      h_q       <= h_q ^ (h_q >> HASH_SH_D);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      h_q       <= h_q << 1;
      rem_q     <= rem_next;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign rem_ext = 32'(rem_q);
  assign mem_idx = rem_ext[IDX_W-1:0];

  // store port: clearing sweep or request access
  always_comb begin
    mem_we    = cmd_i.clr_we ||
                (cmd_i.mem_op && (kind_q == KIND_ADD || kind_q == KIND_DEL));
    mem_addr  = cmd_i.clr_we ? clr_q : mem_idx;
    mem_wdata = (cmd_i.clr_we || kind_q == KIND_DEL) ? '0 : value_q;
  end

  // bucket store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (cmd_i.mem_op) rd_q <= mem_q[mem_addr];
  end

  // response registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      read_value_q <= (kind_q == KIND_GET) ? rd_q : '0;
      bucket_q     <= rem_ext[BUCKET_W-1:0];
    end
  end

  assign read_value_o   = read_value_q;
  assign bucket_o       = bucket_q;
  assign sts_o.clr_last = (clr_q == IDX_W'(MAX_BUCKETS - 1));
  assign sts_o.div_last = (div_cnt_q == '1);

`ifndef SYNTHESIS
  // partial remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < eff_count))
    else $error("remainder out of range");

  // clearing sweep wraps back to the first entry
  a_clr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clr_we && sts_o.clr_last) |=> (clr_q == '0))
    else $error("clear counter did not wrap");
`endif

endmodule

// ===== hdl/hashed_direct_value_table_top.sv =====
// top level of the hashed direct value table
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   kind, key, value
//   rsp_o    out  valid/ready   read_value, bucket
//   cfg_i    in   valid/ready   data (bucket count)
//
// each request runs through acceptance, a low and a high multiply step, a fold,
// the bit-serial remainder of all 64 hash bits by the bucket count, store
// access and response load.
// after reset a clearing pass zeroes all MAX_BUCKETS entries of the store,
// with req_i.ready low; configuration writes are taken at any time.
// a finished response waits in the output register while the next request
// is taken; a stalled rsp_o holds only the response step.
module hashed_direct_value_table_top #(
  parameter int MAX_BUCKETS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hdvt_req_if.sink          req_i,
  hdvt_rsp_if.source        rsp_o,
  hdvt_cfg_if.sink          cfg_i
);
  import hdvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  // controller
  hdvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath
  hdvt_dp #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (req_i.kind),
    .key_i        (req_i.key),
    .value_i      (req_i.value),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .read_value_o (rsp_o.read_value),
    .bucket_o     (rsp_o.bucket)
  );

endmodule
